@@ hw/rtl/evap_cooler_controller_core_macros.svh @@
// Assertion macros for the evaporative cooler controller.
// Included by the RTL files that carry concurrent assertions.
`ifndef EVAP_COOLER_CONTROLLER_CORE_MACROS_SVH
`define EVAP_COOLER_CONTROLLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is high.
`define EVC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define EVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EVC_ASSERT(lbl, clk, rst, prop, msg)
`define EVC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hw/rtl/evc_pkg.sv @@
// Shared types, codes and constants of the evaporative cooler controller.
// No dependencies; imported by every module of the block.
package evc_pkg;

  // Event codes carried in the mode field.
  typedef enum logic [2:0] {
    EV_TICK  = 3'd0,
    EV_ON    = 3'd1,
    EV_OFF   = 3'd2,
    EV_TEMP  = 3'd3,
    EV_PURGE = 3'd4
  } evc_event_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_COOLING_MODE   = 3'd0,
    REG_STAGE_ENABLE   = 3'd1,
    REG_MED_THRESHOLD  = 3'd2,
    REG_HIGH_THRESHOLD = 3'd3,
    REG_FAN_DELAY      = 3'd4,
    REG_PURGE_TIME     = 3'd5,
    REG_PURGE_INTERVAL = 3'd6,
    REG_FILTER_ALLOW   = 3'd7
  } evc_reg_t;

  // Cooling modes.
  localparam logic [1:0] MODE_NORMAL     = 2'd0;
  localparam logic [1:0] MODE_NORMAL_MED = 2'd1;
  localparam logic [1:0] MODE_PASSIVE    = 2'd2;
  localparam logic [1:0] MODE_FAN_ONLY   = 2'd3;

  // Fan stages.
  localparam logic [1:0] STAGE_OFF  = 2'd0;
  localparam logic [1:0] STAGE_LOW  = 2'd1;
  localparam logic [1:0] STAGE_MED  = 2'd2;
  localparam logic [1:0] STAGE_HIGH = 2'd3;

  // Half a degree of hysteresis, in sixteenths.
  localparam logic signed [12:0] HYST     = 13'sd8;
  localparam logic signed [12:0] NEG_HYST = -13'sd8;

  localparam logic [31:0] FILTER_ALLOW_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [11:0] temperature;
  } evc_in_t;

  typedef struct packed {
    logic        unit_on;
    logic        pump_on;
    logic [1:0]  fan_speed;
    logic        fan_low_on;
    logic        fan_med_on;
    logic        fan_high_on;
    logic        purge_pump_on;
    logic        filter_due;
    logic [31:0] filter_used_s;
  } evc_out_t;

  typedef struct packed {
    logic [1:0]         cooling_mode;
    logic [1:0]         stage_enable;
    logic signed [11:0] med_threshold;
    logic signed [11:0] high_threshold;
    logic [9:0]         fan_delay_s;
    logic [11:0]        purge_time_s;
    logic [10:0]        purge_interval_min;
    logic [31:0]        filter_allowance_s;
  } evc_cfg_t;

  typedef struct packed {
    logic        on_flag;
    logic        pump_flag;
    logic [1:0]  fan_stage;
    logic        start_pending;
    logic [9:0]  start_countdown;
    logic        purge_cycle_active;
    logic [16:0] purge_cycle_count;
    logic        purge_flag;
    logic [11:0] purge_countdown;
    logic        fan_running;
    logic [31:0] run_seconds;
    logic [31:0] filter_used;
  } evc_state_t;

endpackage

@@ hw/rtl/evc_cfg.sv @@
// Configuration register file of the evaporative cooler controller.
// Depends on evc_pkg for the register indexes and the configuration struct.
module evc_cfg import evc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data,
  output evc_cfg_t    cfg
);

  // Register writes, one register per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cooling_mode       <= MODE_NORMAL;
      cfg.stage_enable       <= 2'd0;
      cfg.med_threshold      <= 12'sd0;
      cfg.high_threshold     <= 12'sd0;
      cfg.fan_delay_s        <= 10'd0;
      cfg.purge_time_s       <= 12'd0;
      cfg.purge_interval_min <= 11'd0;
      cfg.filter_allowance_s <= FILTER_ALLOW_RESET;
    end else if (wr_en) begin
      unique case (evc_reg_t'(wr_index))
        REG_COOLING_MODE:   cfg.cooling_mode       <= wr_data[1:0];
        REG_STAGE_ENABLE:   cfg.stage_enable       <= wr_data[1:0];
        REG_MED_THRESHOLD:  cfg.med_threshold      <= wr_data[11:0];
        REG_HIGH_THRESHOLD: cfg.high_threshold     <= wr_data[11:0];
        REG_FAN_DELAY:      cfg.fan_delay_s        <= wr_data[9:0];
        REG_PURGE_TIME:     cfg.purge_time_s       <= wr_data[11:0];
        REG_PURGE_INTERVAL: cfg.purge_interval_min <= wr_data[10:0];
        REG_FILTER_ALLOW:   cfg.filter_allowance_s <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/evc_seq.sv @@
// Sequencer state and its update for each event word.
// Depends on evc_pkg and on the assertion macros header.
`include "evap_cooler_controller_core_macros.svh"
module evc_seq import evc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  evc_cfg_t cfg,
  input  logic     step,
  input  evc_in_t  item,
  output evc_out_t result
);

  evc_state_t st;
  evc_state_t st_next;
  logic        due;
  logic        do_start;
  logic        do_purge;
  logic [16:0] limit;
  logic [16:0] cyc_next;
  logic [32:0] sum;
  logic signed [12:0] dm;
  logic signed [12:0] dh;
  logic [1:0]  stg;

  // Purge period in seconds: minutes times 64 minus minutes times 4.
  assign limit    = {cfg.purge_interval_min, 6'b0} - {4'b0, cfg.purge_interval_min, 2'b0};
  assign cyc_next = st.purge_cycle_count + 17'd1;
  assign sum      = {1'b0, st.filter_used} + {1'b0, st.run_seconds};
  assign dm = {item.temperature[11], item.temperature}
            - {cfg.med_threshold[11], cfg.med_threshold};
  assign dh = {item.temperature[11], item.temperature}
            - {cfg.high_threshold[11], cfg.high_threshold};

  // Next state for the current event word.
  always_comb begin
    st_next  = st;
    due      = 1'b0;
    do_start = 1'b0;
    do_purge = 1'b0;
    stg      = st.fan_stage;
    unique case (item.mode)
      EV_TICK: begin
        if (st.start_pending) begin
          if (st.start_countdown <= 10'd1) begin
            st_next.start_pending   = 1'b0;
            st_next.start_countdown = 10'd0;
            do_start                = 1'b1;
          end else begin
            st_next.start_countdown = st.start_countdown - 10'd1;
          end
        end
        if (st.purge_flag) begin
          if (st.purge_countdown <= 12'd1) begin
            st_next.purge_flag      = 1'b0;
            st_next.purge_countdown = 12'd0;
          end else begin
            st_next.purge_countdown = st.purge_countdown - 12'd1;
          end
        end
        if (st.purge_cycle_active && cfg.purge_interval_min != 11'd0) begin
          if (cyc_next >= limit) begin
            st_next.purge_cycle_count = 17'd0;
            do_purge                  = 1'b1;
          end else begin
            st_next.purge_cycle_count = cyc_next;
          end
        end
        if (st.fan_running && st.run_seconds != 32'hFFFF_FFFF) begin
          st_next.run_seconds = st.run_seconds + 32'd1;
        end
        if (do_purge) begin
          st_next.purge_flag      = 1'b1;
          st_next.purge_countdown = cfg.purge_time_s;
        end
        if (do_start) begin
          st_next.fan_stage   = (cfg.cooling_mode == MODE_NORMAL_MED) ? STAGE_MED : STAGE_LOW;
          st_next.fan_running = 1'b1;
          st_next.run_seconds = 32'd0;
          if (cfg.purge_interval_min != 11'd0 && cfg.cooling_mode != MODE_FAN_ONLY) begin
            st_next.purge_cycle_active = 1'b1;
            st_next.purge_cycle_count  = 17'd0;
          end
        end
      end
      EV_ON: begin
        if (!st.on_flag) begin
          if (cfg.cooling_mode != MODE_FAN_ONLY) begin
            st_next.pump_flag = 1'b1;
          end
          if (cfg.cooling_mode == MODE_NORMAL || cfg.cooling_mode == MODE_NORMAL_MED) begin
            st_next.start_pending   = 1'b1;
            st_next.start_countdown = cfg.fan_delay_s;
          end else if (cfg.cooling_mode == MODE_FAN_ONLY) begin
            st_next.start_pending   = 1'b1;
            st_next.start_countdown = 10'd1;
          end
          st_next.on_flag = 1'b1;
        end
      end
      EV_OFF: begin
        st_next.fan_stage       = STAGE_OFF;
        st_next.pump_flag       = 1'b0;
        st_next.start_pending   = 1'b0;
        st_next.start_countdown = 10'd0;
        if (st.purge_cycle_active) begin
          st_next.purge_cycle_active = 1'b0;
          st_next.purge_cycle_count  = 17'd0;
          st_next.purge_flag         = 1'b1;
          st_next.purge_countdown    = cfg.purge_time_s;
        end
        st_next.on_flag = 1'b0;
        if (st.fan_running) begin
          st_next.filter_used = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        st_next.fan_running = 1'b0;
        st_next.run_seconds = 32'd0;
        due = st_next.filter_used > cfg.filter_allowance_s;
      end
      EV_TEMP: begin
        // Medium step first; the high step sees its outcome.
        if (st.on_flag) begin
          if (cfg.stage_enable[0]) begin
            if (stg == STAGE_LOW && dm > HYST) begin
              stg = STAGE_MED;
            end else if (stg == STAGE_MED && dm < NEG_HYST) begin
              stg = STAGE_LOW;
            end
          end
          if (cfg.stage_enable[1]) begin
            if (stg == STAGE_MED && dh > HYST) begin
              stg = STAGE_HIGH;
            end else if (stg == STAGE_HIGH && dh < NEG_HYST) begin
              stg = STAGE_MED;
            end
          end
          st_next.fan_stage = stg;
        end
      end
      EV_PURGE: begin
        st_next.purge_flag      = 1'b1;
        st_next.purge_countdown = cfg.purge_time_s;
      end
      default: ;
    endcase
  end

  // Result word shows the state after the event.
  always_comb begin
    result.unit_on       = st_next.on_flag;
    result.pump_on       = st_next.pump_flag;
    result.fan_speed     = st_next.fan_stage;
    result.fan_low_on    = st_next.fan_stage == STAGE_LOW;
    result.fan_med_on    = st_next.fan_stage == STAGE_MED && cfg.stage_enable[0];
    result.fan_high_on   = st_next.fan_stage == STAGE_HIGH && cfg.stage_enable[1];
    result.purge_pump_on = st_next.purge_flag;
    result.filter_due    = due;
    result.filter_used_s = st_next.filter_used;
  end

  // State register, updated once per event word.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

  `EVC_ASSERT(a_due_only_off, clk, rst, (step && result.filter_due) |-> (item.mode == EV_OFF), "filter_due outside turn off")
  `EVC_ASSERT(a_off_stops_fan, clk, rst, (step && item.mode == EV_OFF) |=> (!st.on_flag && st.fan_stage == STAGE_OFF && !st.fan_running), "turn off left the fan running")
  `EVC_ASSERT(a_filter_monotonic, clk, rst, step |=> (st.filter_used >= $past(st.filter_used)), "filter use count went down")
  `EVC_ASSERT(a_one_drive, clk, rst, $onehot0({result.fan_low_on, result.fan_med_on, result.fan_high_on}), "more than one fan drive")

endmodule

@@ hw/rtl/evap_cooler_controller_core.sv @@
// Top level of the evaporative cooler controller: event and result registers.
// Depends on evc_pkg, evc_cfg and evc_seq.
//
//   channel   direction  handshake                payload
//   event     in         event_valid/event_ready  event_word (evc_in_t)
//   result    out        result_valid/result_ready result_word (evc_out_t)
//   cfg       in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// One event word is taken per cycle while results are taken; it passes the event register
// and the sequencer update into the result register. When the result is not taken, the
// event register holds one more word, then ready drops. Configuration writes are taken in
// every cycle. Synchronous reset resets all state but the event and result data registers.
module evap_cooler_controller_core import evc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        event_valid,
  output logic        event_ready,
  input  evc_in_t     event_word,
  output logic        result_valid,
  input  logic        result_ready,
  output evc_out_t    result_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  evc_cfg_t cfg;
  evc_in_t  item;
  logic     item_valid;
  logic     advance;
  evc_out_t result;

  assign cfg_ready   = 1'b1;
  assign advance     = item_valid && (!result_valid || result_ready);
  assign event_ready = !item_valid || advance;

  evc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  evc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  // Event register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (event_ready) begin
      item_valid <= event_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (event_ready && event_valid) begin
      item <= event_word;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_word <= result;
    end
  end

endmodule
